FILE: sv/ptrq_pkg.sv
// shared types and constants for the priority task ready queue
package ptrq_pkg;

	// fixed field widths
	localparam int ID_W       = 3;
	localparam int COUNT_W    = 4;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MASK_W     = 8;

	// parameter defaults
	localparam int NUM_TASKS_DEF = 8;
	localparam int PRIO_BITS_DEF = 4;

	// request codes
	localparam logic [REQ_W-1:0] REQ_START     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACTIVATE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TERMINATE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_DISPATCH  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_PRIORITIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_START_MASK = 2'd1;

	// result status codes
	localparam logic RESP_OK  = 1'b0;
	localparam logic RESP_ERR = 1'b1;

	// request item
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ID_W-1:0]  task_id;
		logic             holds_resources;
	} in_item_t;

	// result item
	typedef struct packed {
		logic               status;
		logic               running_valid;
		logic [ID_W-1:0]    running_task;
		logic [COUNT_W-1:0] ready_count;
		logic [ID_W-1:0]    ready_head;
	} out_item_t;

endpackage

FILE: sv/priority_task_ready_queue.sv
// task-state table with a priority-ordered ready list and its request sequencer
//
// One request item is taken at a time; in_ready is high only while the sequencer
// is idle, and a finished result waits in the output register without holding off
// the next item. Terminate and dispatch pass through the execute and done states
// before their result is registered. Activate passes through execute, the insert
// and done; the insert walks the list from its tail past each ready task of lower
// priority with a single priority comparator, one entry per cycle. Start clears
// the table, scans the auto-start mask in ascending id order and reuses the same
// insert for each auto-start task, then ends in done. The next item is taken once
// the sequencer is back in idle after the result is registered, or later while an
// earlier result is still waiting to be taken. Priority values of tasks whose
// field lies above bit 31 of task_priorities read as zero.
module priority_task_ready_queue #(
	parameter int NUM_TASKS = ptrq_pkg::NUM_TASKS_DEF,
	parameter int PRIO_BITS = ptrq_pkg::PRIO_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ptrq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptrq_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ptrq_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ptrq_pkg::out_item_t                out_item
);

	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int PW    = NUM_TASKS * PRIO_BITS;

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_INS, S_DONE} state_t;
	typedef enum logic [1:0] {TS_SUSP, TS_READY, TS_RUN} tstat_t;

	state_t                              state_q;
	ptrq_pkg::in_item_t                  req_q;
	logic [ptrq_pkg::CFG_DATA_W-1:0]     prio_q;
	logic [ptrq_pkg::MASK_W-1:0]         mask_q;
	tstat_t                              tstat_q [NUM_TASKS];
	logic [ptrq_pkg::ID_W-1:0]           order_q [NUM_TASKS];
	logic [CNT_W-1:0]                    len_q;
	logic                                run_valid_q;
	logic [ptrq_pkg::ID_W-1:0]           run_id_q;
	logic [CNT_W-1:0]                    scan_q;
	logic [CNT_W-1:0]                    k_q;
	logic [ptrq_pkg::ID_W-1:0]           ins_id_q;
	logic [PRIO_BITS-1:0]                ins_prio_q;
	logic                                err_q;
	logic                                out_valid_q;
	ptrq_pkg::out_item_t                 out_q;

	logic [PW+31:0]                      prio_ext;
	logic [CNT_W-1:0]                    k_m1;
	logic [ptrq_pkg::ID_W-1:0]           prev_id;
	logic                                place;
	logic [IDX_W-1:0]                    tid_idx;
	logic                                act_ok;
	logic                                term_ok;
	logic                                disp_ok;
	logic                                pop;

	// priority field of one task, zero above bit 31
	function automatic logic [PRIO_BITS-1:0] prio_of(input logic [PW+31:0] v,
			input logic [IDX_W-1:0] id);
		return v[int'(id) * PRIO_BITS +: PRIO_BITS];
	endfunction

	assign prio_ext = {{PW{1'b0}}, prio_q};

	// insert step: compare with the entry just ahead of the hole
	assign k_m1    = k_q - 1'b1;
	assign prev_id = order_q[k_m1[IDX_W-1:0]];
	assign place   = (k_q == '0) ||
		(prio_of(prio_ext, prev_id[IDX_W-1:0]) >= ins_prio_q);

	// request checks
	assign tid_idx = req_q.task_id[IDX_W-1:0];
	assign act_ok  = (32'(req_q.task_id) < NUM_TASKS) && (tstat_q[tid_idx] == TS_SUSP) &&
		(len_q < CNT_W'(NUM_TASKS));
	assign term_ok = run_valid_q && !req_q.holds_resources;
	assign disp_ok = (len_q != '0) && !run_valid_q;
	assign pop     = (state_q == S_EXEC) && (req_q.req_type == ptrq_pkg::REQ_DISPATCH) &&
		disp_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// ready list entries
	always_ff @(posedge clk) begin
		if (state_q == S_INS) begin
			order_q[k_q[IDX_W-1:0]] <= place ? ins_id_q : prev_id;
		end else if (pop) begin
			for (int i = 0; i < NUM_TASKS - 1; i++) begin
				order_q[i] <= order_q[i + 1];
			end
		end
	end

	// sequencer, task table and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prio_q      <= '0;
			mask_q      <= '0;
			len_q       <= '0;
			run_valid_q <= 1'b0;
			run_id_q    <= '0;
			scan_q      <= '0;
			k_q         <= '0;
			ins_id_q    <= '0;
			ins_prio_q  <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			req_q       <= '0;
			out_q       <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				tstat_q[i] <= TS_SUSP;
			end
		end else begin
			// configuration writes
			if (cfg_we) begin
				if (cfg_index == ptrq_pkg::CFG_TASK_PRIORITIES) begin
					prio_q <= cfg_data;
				end else if (cfg_index == ptrq_pkg::CFG_AUTO_START_MASK) begin
					mask_q <= cfg_data[ptrq_pkg::MASK_W-1:0];
				end
			end

			// result handed on, unless a new one is loaded this cycle
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q.req_type)
						ptrq_pkg::REQ_START: begin
							for (int i = 0; i < NUM_TASKS; i++) begin
								tstat_q[i] <= TS_SUSP;
							end
							len_q       <= '0;
							run_valid_q <= 1'b0;
							run_id_q    <= '0;
							scan_q      <= '0;
							err_q       <= ptrq_pkg::RESP_OK;
							state_q     <= S_SCAN;
						end
						ptrq_pkg::REQ_ACTIVATE: begin
							if (act_ok) begin
								ins_id_q   <= req_q.task_id;
								ins_prio_q <= prio_of(prio_ext, tid_idx);
								k_q        <= len_q;
								err_q      <= ptrq_pkg::RESP_OK;
								state_q    <= S_INS;
							end else begin
								err_q   <= ptrq_pkg::RESP_ERR;
								state_q <= S_DONE;
							end
						end
						ptrq_pkg::REQ_TERMINATE: begin
							state_q <= S_DONE;
							if (term_ok) begin
								tstat_q[run_id_q[IDX_W-1:0]] <= TS_SUSP;
								run_valid_q <= 1'b0;
								run_id_q    <= '0;
								err_q       <= ptrq_pkg::RESP_OK;
							end else begin
								err_q <= ptrq_pkg::RESP_ERR;
							end
						end
						default: begin
							state_q <= S_DONE;
							if (disp_ok) begin
								run_id_q    <= order_q[0];
								run_valid_q <= 1'b1;
								len_q       <= len_q - 1'b1;
								tstat_q[order_q[0][IDX_W-1:0]] <= TS_RUN;
								err_q       <= ptrq_pkg::RESP_OK;
							end else begin
								err_q <= ptrq_pkg::RESP_ERR;
							end
						end
					endcase
				end
				S_SCAN: begin
					// walk the auto-start mask in ascending id order
					if (scan_q == CNT_W'(NUM_TASKS)) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
						if (mask_q[ptrq_pkg::ID_W'(scan_q[IDX_W-1:0])]) begin
							ins_id_q   <= ptrq_pkg::ID_W'(scan_q[IDX_W-1:0]);
							ins_prio_q <= prio_of(prio_ext, scan_q[IDX_W-1:0]);
							k_q        <= len_q;
							state_q    <= S_INS;
						end
					end
				end
				S_INS: begin
					// move the hole forward until an entry of equal or higher priority
					if (place) begin
						len_q <= len_q + 1'b1;
						tstat_q[ins_id_q[IDX_W-1:0]] <= TS_READY;
						state_q <= (req_q.req_type == ptrq_pkg::REQ_START) ? S_SCAN : S_DONE;
					end else begin
						k_q <= k_m1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.status        <= err_q;
						out_q.running_valid <= run_valid_q;
						out_q.running_task  <= run_valid_q ? run_id_q : '0;
						out_q.ready_count   <= ptrq_pkg::COUNT_W'(len_q);
						out_q.ready_head    <= (len_q != '0) ? order_q[0] : '0;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
